>>> rtl/core/rsps_pkg.sv
`default_nettype none

package rsps_pkg;

   // word width of the field; the pool and the echelon basis hold 64 entries
   localparam int FIELD_M    = 64;
   localparam int POOL_DEPTH = 64;
   localparam int ADDR_W     = 6;

   localparam logic [63:0] WORD_MASK = {64{1'b1}} >> (64 - FIELD_M);
   localparam logic [ADDR_W-1:0] TOP_BIT = ADDR_W'(FIELD_M - 1);
   localparam logic [6:0] FIELD_M_W7 = 7'(FIELD_M);
   localparam logic [7:0] FIELD_M_W8 = 8'(FIELD_M);
   localparam logic [6:0] POOL_FULL_W7 = 7'(POOL_DEPTH);
   localparam logic [15:0] ATTEMPT_LIMIT_RESET = 16'd4096;
   localparam logic [15:0] ATTEMPT_SAT = 16'hFFFF;

   // request commands
   localparam logic CMD_START     = 1'b0;
   localparam logic CMD_CANDIDATE = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_POOL     = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_BAD_DIMS = 2'd2;
   localparam logic [1:0] STATUS_REJECT   = 2'd3;

   // register indexes
   localparam logic [2:0] REG_FIRST_RANK    = 3'd0;
   localparam logic [2:0] REG_SECOND_RANK   = 3'd1;
   localparam logic [2:0] REG_SHARED_DIM    = 3'd2;
   localparam logic [2:0] REG_ONE_IN_SECOND = 3'd3;
   localparam logic [2:0] REG_ATTEMPT_LIMIT = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_EMIT_RD,
      ST_EMIT_SHOW,
      ST_STATUS
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/random_subspace_pair_sampler_unit.sv
`default_nettype none

// GF(2) independent-word pool sampler. A start request checks the rank
// registers, clears the pool and, with one_in_second set, seeds it with the
// word 1; then candidate requests are reduced against an echelon basis kept
// in a 64-entry synchronous memory and appended to a second 64-entry pool
// memory when independent. A nonzero candidate is accepted in ST_IDLE; ST_SCAN
// walks the echelon rows from the top pivot down (one row read per cycle, the
// read of the next row overlapping the xor of the current one); then ST_CHECK
// tests for a complete pool or an exhausted attempt budget. A start or a
// zero candidate skips the scan, and a candidate offered while no sampling
// runs is dropped. Once the pool holds union_size words every word is sent
// in pool order, read in ST_EMIT_RD and shown in ST_EMIT_SHOW until taken
// on rsp_; a status result waits in ST_STATUS until taken. req_stall stays
// high until idle; a write to the three rank registers drops later candidates.
module random_subspace_pair_sampler_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_cmd,
   input  wire logic [63:0] req_candidate,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [63:0]      rsp_element,
   output logic             rsp_in_first,
   output logic [5:0]       rsp_first_index,
   output logic             rsp_in_second,
   output logic [5:0]       rsp_second_index,
   output logic             rsp_last,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import rsps_pkg::*;

   state_type state_ff, state_in;

   logic [6:0]  first_rank_ff, second_rank_ff, shared_dim_ff;
   logic        one_in_second_ff;
   logic [15:0] attempt_limit_ff;

   logic [63:0] pv_ff, pv_in;
   logic [6:0]  count_ff, count_in;
   logic [15:0] attempt_ff, attempt_in;
   logic        active_ff, active_in;

   logic [63:0] r_ff, r_in;
   logic [63:0] word_ff, word_in;
   logic [ADDR_W-1:0] bit_ff, bit_in;
   logic        found_ff, found_in;
   logic [ADDR_W-1:0] pivot_ff, pivot_in;
   logic [ADDR_W-1:0] emit_idx_ff, emit_idx_in;
   logic [1:0]  status_ff, status_in;

   logic [63:0] ech_mem [POOL_DEPTH];
   logic [63:0] pool_mem [POOL_DEPTH];
   logic [63:0] ech_rd_ff, pool_rd_ff;

   logic              ech_we, pool_we, pool_re;
   logic [ADDR_W-1:0] ech_wa, ech_ra, pool_wa;
   logic [63:0]       ech_wd, pool_wd;

   logic [7:0]  union_size;
   logic        dims_ok;
   logic        req_fire, rsp_fire;
   logic [63:0] cand_masked;
   logic        use_row, hit;
   logic [63:0] r_step;
   logic        found_step;
   logic [ADDR_W-1:0] pivot_step;
   logic [6:0]  emit_p;
   logic        lab_in_first, lab_in_second;

   assign union_size = 8'({1'b0, first_rank_ff} + {1'b0, second_rank_ff}
                          - {1'b0, shared_dim_ff});
   assign dims_ok = (shared_dim_ff <= first_rank_ff) && (shared_dim_ff <= second_rank_ff)
                    && (first_rank_ff <= FIELD_M_W7) && (second_rank_ff <= FIELD_M_W7)
                    && (union_size <= FIELD_M_W8);

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_fire    = req_valid && !req_stall;
   assign rsp_valid   = (state_ff == ST_EMIT_SHOW) || (state_ff == ST_STATUS);
   assign rsp_fire    = rsp_valid && !rsp_stall;
   assign cand_masked = req_candidate & WORD_MASK;

   // one reduction step at bit bit_ff with the row read in the previous cycle
   assign use_row    = r_ff[bit_ff] & pv_ff[bit_ff];
   assign r_step     = r_ff ^ (use_row ? ech_rd_ff : 64'd0);
   assign hit        = r_ff[bit_ff] & ~pv_ff[bit_ff] & ~found_ff;
   assign found_step = found_ff | hit;
   assign pivot_step = hit ? bit_ff : pivot_ff;

   // first row read is issued while the candidate is accepted
   assign ech_ra = (state_ff == ST_SCAN) ? bit_ff - 1'b1 : TOP_BIT;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_rank_ff    <= '0;
         second_rank_ff   <= '0;
         shared_dim_ff    <= '0;
         one_in_second_ff <= 1'b0;
         attempt_limit_ff <= ATTEMPT_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_FIRST_RANK:    first_rank_ff    <= csr_wdata[6:0];
            REG_SECOND_RANK:   second_rank_ff   <= csr_wdata[6:0];
            REG_SHARED_DIM:    shared_dim_ff    <= csr_wdata[6:0];
            REG_ONE_IN_SECOND: one_in_second_ff <= csr_wdata[0];
            REG_ATTEMPT_LIMIT: attempt_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pv_ff      <= '0;
         count_ff   <= '0;
         attempt_ff <= '0;
         active_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pv_ff      <= pv_in;
         count_ff   <= count_in;
         attempt_ff <= attempt_in;
         active_ff  <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff        <= r_in;
      word_ff     <= word_in;
      bit_ff      <= bit_in;
      found_ff    <= found_in;
      pivot_ff    <= pivot_in;
      emit_idx_ff <= emit_idx_in;
      status_ff   <= status_in;
   end

   // writes land only at the end of a scan or on a start, so no scan
   // ever reads a row that is being written
   always_ff @(posedge clock) begin
      if (ech_we) begin
         ech_mem[ech_wa] <= ech_wd;
      end
      ech_rd_ff <= ech_mem[ech_ra];
   end

   always_ff @(posedge clock) begin
      if (pool_we) begin
         pool_mem[pool_wa] <= pool_wd;
      end
      if (pool_re) begin
         pool_rd_ff <= pool_mem[emit_idx_ff];
      end
   end

   always_comb begin
      state_in    = state_ff;
      pv_in       = pv_ff;
      count_in    = count_ff;
      attempt_in  = attempt_ff;
      active_in   = active_ff;
      r_in        = r_ff;
      word_in     = word_ff;
      bit_in      = bit_ff;
      found_in    = found_ff;
      pivot_in    = pivot_ff;
      emit_idx_in = emit_idx_ff;
      status_in   = status_ff;
      ech_we      = 1'b0;
      ech_wa      = '0;
      ech_wd      = 64'd1;
      pool_we     = 1'b0;
      pool_wa     = '0;
      pool_wd     = 64'd1;
      pool_re     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_cmd == CMD_START) begin
                  if (!dims_ok) begin
                     status_in = STATUS_BAD_DIMS;
                     active_in = 1'b0;
                     state_in  = ST_STATUS;
                  end else begin
                     pv_in      = '0;
                     count_in   = '0;
                     attempt_in = '0;
                     active_in  = 1'b1;
                     if (union_size == 8'd0) begin
                        status_in = STATUS_EMPTY;
                        active_in = 1'b0;
                        state_in  = ST_STATUS;
                     end else begin
                        if (one_in_second_ff) begin
                           // seed word 1 has its pivot at bit 0
                           ech_we   = 1'b1;
                           pool_we  = 1'b1;
                           pv_in    = 64'd1;
                           count_in = 7'd1;
                        end
                        state_in = ST_CHECK;
                     end
                  end
               end else if (active_ff) begin
                  if (attempt_ff != ATTEMPT_SAT) begin
                     attempt_in = attempt_ff + 16'd1;
                  end
                  if ((cand_masked == 64'd0) || (count_ff >= POOL_FULL_W7)) begin
                     state_in = ST_CHECK;
                  end else begin
                     r_in     = cand_masked;
                     word_in  = cand_masked;
                     bit_in   = TOP_BIT;
                     found_in = 1'b0;
                     pivot_in = '0;
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            r_in     = r_step;
            found_in = found_step;
            pivot_in = pivot_step;
            if (bit_ff == '0) begin
               if (found_step) begin
                  ech_we   = 1'b1;
                  ech_wa   = pivot_step;
                  ech_wd   = r_step;
                  pool_we  = 1'b1;
                  pool_wa  = count_ff[ADDR_W-1:0];
                  pool_wd  = word_ff;
                  pv_in    = pv_ff | (64'd1 << pivot_step);
                  count_in = count_ff + 7'd1;
               end
               state_in = ST_CHECK;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         ST_CHECK: begin
            if ({1'b0, count_ff} >= union_size) begin
               active_in   = 1'b0;
               emit_idx_in = '0;
               state_in    = ST_EMIT_RD;
            end else if (attempt_ff >= attempt_limit_ff) begin
               active_in = 1'b0;
               status_in = STATUS_REJECT;
               state_in  = ST_STATUS;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            pool_re  = 1'b1;
            state_in = ST_EMIT_SHOW;
         end
         ST_EMIT_SHOW: begin
            if (rsp_fire) begin
               if (emit_p + 7'd1 == count_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + 1'b1;
                  state_in    = ST_EMIT_RD;
               end
            end
         end
         ST_STATUS: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a rank write ends the running sampling for later candidates
      if (csr_we && ((csr_index == REG_FIRST_RANK) || (csr_index == REG_SECOND_RANK)
                     || (csr_index == REG_SHARED_DIM))) begin
         active_in = 1'b0;
      end
   end

   // labels of the word at pool index emit_p
   assign emit_p        = {1'b0, emit_idx_ff};
   assign lab_in_first  = emit_p < first_rank_ff;
   assign lab_in_second = (emit_p < shared_dim_ff) || (emit_p >= first_rank_ff);

   always_comb begin
      rsp_status       = status_ff;
      rsp_element      = '0;
      rsp_in_first     = 1'b0;
      rsp_first_index  = '0;
      rsp_in_second    = 1'b0;
      rsp_second_index = '0;
      rsp_last         = 1'b1;
      if (state_ff == ST_EMIT_SHOW) begin
         rsp_status      = STATUS_POOL;
         rsp_element     = pool_rd_ff;
         rsp_in_first    = lab_in_first;
         rsp_first_index = lab_in_first ? emit_idx_ff : 6'd0;
         rsp_in_second   = lab_in_second;
         if (emit_p < shared_dim_ff) begin
            rsp_second_index = emit_idx_ff;
         end else if (emit_p >= first_rank_ff) begin
            rsp_second_index = 6'(shared_dim_ff + emit_p - first_rank_ff);
         end
         rsp_last = (emit_p + 7'd1 == count_ff);
      end
   end

endmodule

`default_nettype wire
